/* rtl/cce_pkg.sv */
// ----------------------------------------------------------------------------
// CSV column extractor package
// Shared constants, codes and record types for the CSV column extractor.
// ----------------------------------------------------------------------------
package cce_pkg;

	localparam int unsigned MAX_RESULTS      = 4;
	localparam int unsigned RES_COUNT_W      = $clog2(MAX_RESULTS + 1);
	localparam int unsigned FIFO_DEPTH       = 16;
	localparam int unsigned FIFO_AW          = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW          = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned FIFO_STALL_LEVEL = FIFO_DEPTH - 2 * MAX_RESULTS;

	localparam logic [8:0]  ROW_LIMIT           = 9'd256;
	localparam logic [15:0] HEADER_COLUMN_LIMIT = 16'd64;
	localparam logic [7:0]  FIELD_LENGTH_LIMIT  = 8'd255;
	localparam logic [15:0] FIELD_INDEX_MAX     = 16'hFFFF;

	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic [1:0] MODE_COLUMN = 2'd0;
	localparam logic [1:0] MODE_HEADER = 2'd1;
	localparam logic [1:0] MODE_COUNT  = 2'd2;

	localparam logic REG_MODE          = 1'b0;
	localparam logic REG_TARGET_COLUMN = 1'b1;

	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_PLAIN  = 4'b0010,
		PH_QUOTED = 4'b0100,
		PH_QSEEN  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [8:0]  row_number;
		logic [15:0] col_index;
		logic [7:0]  char_byte;
		logic        has_char;
		logic        field_end;
		logic        is_report;
		logic [8:0]  tally;
		logic        run_last;
	} rec_t;

	typedef struct packed {
		logic [RES_COUNT_W-1:0]   count;
		rec_t [MAX_RESULTS-1:0]   recs;
	} res_t;

	typedef struct packed {
		phase_t                 ph;
		logic [15:0]            fi;
		logic [7:0]             fl;
		logic [8:0]             rc;
		logic                   ls;
		logic                   rf;
		logic [RES_COUNT_W-1:0] n;
		rec_t [MAX_RESULTS-1:0] recs;
	} ctx_t;

endpackage

/* rtl/csv_column_extractor.sv */
// ----------------------------------------------------------------------------
// CSV column extractor
// A byte's first result passes the input register and the result queue
// before it is offered. Throughput: one byte per cycle while in_stall is low;
// results leave one per cycle from a 16-entry queue while out_stall is low,
// and in_stall rises while more than eight results are held.
// Reset: asynchronous, clears parser state and queue; mode 0, target 1.
// ----------------------------------------------------------------------------
module csv_column_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [8:0]  row_number,
	output logic [15:0] col_index,
	output logic [7:0]  char_byte,
	output logic        has_char,
	output logic        field_end,
	output logic        is_report,
	output logic [8:0]  tally,
	output logic        run_last
);

	logic [1:0]                  mode_q;
	logic [15:0]                 target_column_q;
	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        eod_s1;
	cce_pkg::res_t               res;
	cce_pkg::rec_t               head;
	logic [cce_pkg::FIFO_CW-1:0] level;

	assign in_stall = (level > cce_pkg::FIFO_CW'(cce_pkg::FIFO_STALL_LEVEL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= cce_pkg::MODE_COLUMN;
			target_column_q <= 16'd1;
		end else if (cfg_write) begin
			if (cfg_index == cce_pkg::REG_MODE)
				mode_q <= cfg_data[1:0];
			else
				target_column_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid && !in_stall;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eod_s1  <= end_of_data;
		end
	end

	cce_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1),
		.eod_s1        (eod_s1),
		.mode          (mode_q),
		.target_column (target_column_q),
		.res           (res)
	);

	cce_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.pop       (!out_stall),
		.not_empty (out_valid),
		.head      (head),
		.level     (level)
	);

	assign row_number = head.row_number;
	assign col_index  = head.col_index;
	assign char_byte  = head.char_byte;
	assign has_char   = head.has_char;
	assign field_end  = head.field_end;
	assign is_report  = head.is_report;
	assign tally      = head.tally;
	assign run_last   = head.run_last;

endmodule

/* rtl/cce_parser.sv */
// ----------------------------------------------------------------------------
// CSV parser core
// Holds the row and field state and combinationally turns one registered
// text byte into up to four result records.
// ----------------------------------------------------------------------------
module cce_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  logic [7:0]    byte_s1,
	input  logic          eod_s1,
	input  logic [1:0]    mode,
	input  logic [15:0]   target_column,
	output cce_pkg::res_t res
);

	cce_pkg::phase_t ph_q;
	logic [15:0]     fi_q;
	logic [7:0]      fl_q;
	logic [8:0]      rc_q;
	logic            ls_q;
	logic            rf_q;
	cce_pkg::ctx_t   c;

	function automatic cce_pkg::ctx_t put_rec(cce_pkg::ctx_t x, cce_pkg::rec_t r);
		cce_pkg::ctx_t y;
		y = x;
		if (y.n < cce_pkg::RES_COUNT_W'(cce_pkg::MAX_RESULTS)) begin
			y.recs[y.n[1:0]] = r;
			y.n = y.n + 1'b1;
		end
		return y;
	endfunction

	function automatic logic wanted(cce_pkg::ctx_t x, logic [1:0] md, logic [15:0] tc);
		logic w;
		w = 1'b0;
		if (md == cce_pkg::MODE_COLUMN)
			w = (tc != 16'd0) && (x.fi == tc);
		else if (md == cce_pkg::MODE_HEADER)
			w = (x.rc == 9'd1) && (x.fi <= cce_pkg::HEADER_COLUMN_LIMIT);
		return w;
	endfunction

	function automatic cce_pkg::ctx_t content(cce_pkg::ctx_t x, logic [7:0] b,
	                                          logic [1:0] md, logic [15:0] tc);
		cce_pkg::ctx_t y;
		cce_pkg::rec_t r;
		y = x;
		r = '0;
		if (y.fl < cce_pkg::FIELD_LENGTH_LIMIT) begin
			y.fl = y.fl + 8'd1;
			if (wanted(y, md, tc)) begin
				r.row_number = y.rc;
				r.col_index  = y.fi;
				r.char_byte  = b;
				r.has_char   = 1'b1;
				y = put_rec(y, r);
			end
		end
		return y;
	endfunction

	function automatic cce_pkg::ctx_t close_field(cce_pkg::ctx_t x, logic [1:0] md,
	                                              logic [15:0] tc);
		cce_pkg::ctx_t y;
		cce_pkg::rec_t r;
		y = x;
		r = '0;
		if (wanted(y, md, tc)) begin
			r.row_number = y.rc;
			r.col_index  = y.fi;
			r.field_end  = 1'b1;
			y = put_rec(y, r);
		end
		y.ph = cce_pkg::PH_START;
		y.fl = 8'd0;
		return y;
	endfunction

	function automatic cce_pkg::ctx_t end_line(cce_pkg::ctx_t x, logic [1:0] md,
	                                           logic [15:0] tc);
		cce_pkg::ctx_t y;
		cce_pkg::rec_t r;
		y = x;
		r = '0;
		if (y.ph != cce_pkg::PH_START)
			y = close_field(y, md, tc);
		if (md == cce_pkg::MODE_HEADER && y.rc == 9'd1) begin
			r.row_number = 9'd1;
			r.is_report  = 1'b1;
			r.tally      = (y.fi < cce_pkg::HEADER_COLUMN_LIMIT) ? y.fi[8:0]
			               : cce_pkg::HEADER_COLUMN_LIMIT[8:0];
			y = put_rec(y, r);
		end
		y.ls = 1'b0;
		y.ph = cce_pkg::PH_START;
		y.fi = 16'd0;
		y.fl = 8'd0;
		return y;
	endfunction

	function automatic cce_pkg::ctx_t parse_byte(cce_pkg::ctx_t x, logic [7:0] b,
	                                             logic [1:0] md, logic [15:0] tc);
		cce_pkg::ctx_t y;
		logic          go;
		logic          delim;
		y = x;
		go = 1'b1;
		delim = (b == cce_pkg::CH_COMMA) || (b == cce_pkg::CH_TAB);
		if (y.ph == cce_pkg::PH_QSEEN) begin
			if (b == cce_pkg::CH_QUOTE) begin
				y = content(y, b, md, tc);
				y.ph = cce_pkg::PH_QUOTED;
				go = 1'b0;
			end else begin
				y = close_field(y, md, tc);
				if (b == cce_pkg::CH_COMMA)
					go = 1'b0;
			end
		end
		if (go && y.ph == cce_pkg::PH_START) begin
			if (y.fi != cce_pkg::FIELD_INDEX_MAX)
				y.fi = y.fi + 16'd1;
			y.fl = 8'd0;
			if (b == cce_pkg::CH_QUOTE) begin
				y.ph = cce_pkg::PH_QUOTED;
			end else if (delim) begin
				y = close_field(y, md, tc);
			end else begin
				y.ph = cce_pkg::PH_PLAIN;
				y = content(y, b, md, tc);
			end
		end else if (go && y.ph == cce_pkg::PH_PLAIN) begin
			if (delim)
				y = close_field(y, md, tc);
			else
				y = content(y, b, md, tc);
		end else if (go) begin
			if (b == cce_pkg::CH_QUOTE)
				y.ph = cce_pkg::PH_QSEEN;
			else
				y = content(y, b, md, tc);
		end
		return y;
	endfunction

	always_comb begin
		cce_pkg::rec_t r;
		r = '0;
		c.ph   = ph_q;
		c.fi   = fi_q;
		c.fl   = fl_q;
		c.rc   = rc_q;
		c.ls   = ls_q;
		c.rf   = rf_q;
		c.n    = '0;
		c.recs = '0;
		if (!c.rf) begin
			if (byte_s1 == cce_pkg::CH_NEWLINE) begin
				if (c.ls)
					c = end_line(c, mode, target_column);
			end else begin
				if (!c.ls && c.rc >= cce_pkg::ROW_LIMIT) begin
					c.rf = 1'b1;
				end else begin
					if (!c.ls) begin
						c.rc = c.rc + 9'd1;
						c.ls = 1'b1;
						c.fi = 16'd0;
						c.fl = 8'd0;
						c.ph = cce_pkg::PH_START;
					end
					c = parse_byte(c, byte_s1, mode, target_column);
				end
			end
		end
		if (eod_s1) begin
			if (!c.rf && c.ls)
				c = end_line(c, mode, target_column);
			if (mode == cce_pkg::MODE_HEADER && c.rc == 9'd0) begin
				r.row_number = 9'd1;
				r.is_report  = 1'b1;
				c = put_rec(c, r);
			end
			if (mode == cce_pkg::MODE_COUNT) begin
				r = '0;
				r.is_report = 1'b1;
				r.tally     = c.rc;
				c = put_rec(c, r);
			end
			c.ph = cce_pkg::PH_START;
			c.fi = 16'd0;
			c.fl = 8'd0;
			c.rc = 9'd0;
			c.ls = 1'b0;
			c.rf = 1'b0;
		end
		if (c.n != '0)
			c.recs[2'(c.n - 1'b1)].run_last = 1'b1;
	end

	assign res.count = valid_s1 ? c.n : '0;
	assign res.recs  = c.recs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= cce_pkg::PH_START;
			fi_q <= 16'd0;
			fl_q <= 8'd0;
			rc_q <= 9'd0;
			ls_q <= 1'b0;
			rf_q <= 1'b0;
		end else if (valid_s1) begin
			ph_q <= c.ph;
			fi_q <= c.fi;
			fl_q <= c.fl;
			rc_q <= c.rc;
			ls_q <= c.ls;
			rf_q <= c.rf;
		end
	end

endmodule

/* rtl/cce_result_fifo.sv */
// ----------------------------------------------------------------------------
// Result queue
// Takes up to four result records per cycle and hands them out one per
// transfer in order.
// ----------------------------------------------------------------------------
module cce_result_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cce_pkg::res_t                 push,
	input  logic                          pop,
	output logic                          not_empty,
	output cce_pkg::rec_t                 head,
	output logic [cce_pkg::FIFO_CW-1:0]   level
);

	cce_pkg::rec_t                mem [cce_pkg::FIFO_DEPTH];
	logic [cce_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [cce_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [cce_pkg::FIFO_CW-1:0]  count_q;
	logic                         do_pop;

	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];
	assign level     = count_q;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		for (int k = 0; k < cce_pkg::MAX_RESULTS; k++) begin
			if (cce_pkg::RES_COUNT_W'(k) < push.count)
				mem[wr_ptr_q + cce_pkg::FIFO_AW'(k)] <= push.recs[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cce_pkg::FIFO_AW'(push.count);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + cce_pkg::FIFO_CW'(push.count)
			           - cce_pkg::FIFO_CW'(do_pop);
		end
	end

endmodule

/* tb/sv/csv_column_extractor_test.sv */
// ----------------------------------------------------------------------------
// CSV column extractor testbench
// Streams CSV text into the extractor under all three modes and the silent
// fourth one. A built-in predictor tracks rows, fields and quoting, and a
// checker compares every result transfer field by field in order. Directed
// texts cover quoting, empty lines and the field length and header column
// limits. Random rows follow, first with stalls on both sides, then without.
// ----------------------------------------------------------------------------
module csv_column_extractor_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_PARSE_ONLY = 2'd3;
	localparam int         SETTLE_CYCLES   = 8;
	localparam int         STUCK_LIMIT     = 2000;
	localparam int         TEXT_BUDGET     = 10;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_write   = 1'b0;
	logic        cfg_index   = cce_pkg::REG_MODE;
	logic [15:0] cfg_data    = '0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte   = '0;
	logic        end_of_data = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [8:0]  row_number;
	logic [15:0] col_index;
	logic [7:0]  char_byte;
	logic        has_char;
	logic        field_end;
	logic        is_report;
	logic [8:0]  tally;
	logic        run_last;

	csv_column_extractor i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [1:0]      mode_reg   = cce_pkg::MODE_COLUMN;
	logic [15:0]     target_reg = 16'd1;
	cce_pkg::phase_t parse_ph   = cce_pkg::PH_START;
	logic [15:0]     field_idx  = '0;
	int              field_len  = 0;
	int              row_cnt    = 0;
	bit              in_row     = 1'b0;
	bit              rows_full  = 1'b0;

	cce_pkg::rec_t   byte_recs[$];
	cce_pkg::rec_t   pending_recs[$];
	logic [7:0]      text_bytes[$];

	bit idle_on     = 1'b1;
	int stall_left  = 0;
	int errors      = 0;
	int bytes_sent  = 0;
	int texts_sent  = 0;
	int results_cnt = 0;
	int stuck_cnt   = 0;

	function automatic logic [8:0] cap9(int v);
		return (v > 511) ? 9'd511 : v[8:0];
	endfunction

	function automatic void emit(int row, logic [15:0] col, logic [7:0] ch, bit has,
			bit fe, bit rep, int cnt);
		cce_pkg::rec_t r;
		if (byte_recs.size() >= cce_pkg::MAX_RESULTS)
			return;
		r.row_number = cap9(row);
		r.col_index  = col;
		r.char_byte  = ch;
		r.has_char   = has;
		r.field_end  = fe;
		r.is_report  = rep;
		r.tally      = cap9(cnt);
		r.run_last   = 1'b0;
		byte_recs.push_back(r);
	endfunction

	function automatic bit wanted_field();
		case (mode_reg)
			cce_pkg::MODE_COLUMN: return target_reg != 16'd0 && field_idx == target_reg;
			cce_pkg::MODE_HEADER:
				return row_cnt == 1 && field_idx <= cce_pkg::HEADER_COLUMN_LIMIT;
			default:              return 1'b0;
		endcase
	endfunction

	function automatic void add_char(logic [7:0] b);
		if (field_len >= cce_pkg::FIELD_LENGTH_LIMIT)
			return;
		field_len++;
		if (wanted_field())
			emit(row_cnt, field_idx, b, 1'b1, 1'b0, 1'b0, 0);
	endfunction

	function automatic void close_field();
		if (wanted_field())
			emit(row_cnt, field_idx, 8'd0, 1'b0, 1'b1, 1'b0, 0);
		parse_ph  = cce_pkg::PH_START;
		field_len = 0;
	endfunction

	function automatic void parse_char(logic [7:0] b);
		if (parse_ph == cce_pkg::PH_QSEEN) begin
			if (b == cce_pkg::CH_QUOTE) begin
				add_char(b);
				parse_ph = cce_pkg::PH_QUOTED;
				return;
			end
			close_field();
			if (b == cce_pkg::CH_COMMA)
				return;
		end
		if (parse_ph == cce_pkg::PH_START) begin
			if (field_idx != cce_pkg::FIELD_INDEX_MAX)
				field_idx++;
			field_len = 0;
			if (b == cce_pkg::CH_QUOTE) begin
				parse_ph = cce_pkg::PH_QUOTED;
			end else if (b == cce_pkg::CH_COMMA || b == cce_pkg::CH_TAB) begin
				close_field();
			end else begin
				parse_ph = cce_pkg::PH_PLAIN;
				add_char(b);
			end
		end else if (parse_ph == cce_pkg::PH_PLAIN) begin
			if (b == cce_pkg::CH_COMMA || b == cce_pkg::CH_TAB)
				close_field();
			else
				add_char(b);
		end else if (b == cce_pkg::CH_QUOTE) begin
			parse_ph = cce_pkg::PH_QSEEN;
		end else begin
			add_char(b);
		end
	endfunction

	function automatic void end_row();
		int cols;
		if (parse_ph != cce_pkg::PH_START)
			close_field();
		if (mode_reg == cce_pkg::MODE_HEADER && row_cnt == 1) begin
			cols = int'((field_idx < cce_pkg::HEADER_COLUMN_LIMIT) ? field_idx
				: cce_pkg::HEADER_COLUMN_LIMIT);
			emit(1, 16'd0, 8'd0, 1'b0, 1'b0, 1'b1, cols);
		end
		in_row    = 1'b0;
		parse_ph  = cce_pkg::PH_START;
		field_idx = '0;
		field_len = 0;
	endfunction

	function automatic void predict_byte(logic [7:0] b, bit last);
		byte_recs.delete();
		if (!rows_full) begin
			if (b == cce_pkg::CH_NEWLINE) begin
				if (in_row)
					end_row();
			end else if (!in_row && row_cnt >= cce_pkg::ROW_LIMIT) begin
				rows_full = 1'b1;
			end else begin
				if (!in_row) begin
					row_cnt++;
					in_row    = 1'b1;
					field_idx = '0;
					field_len = 0;
					parse_ph  = cce_pkg::PH_START;
				end
				parse_char(b);
			end
		end
		if (last) begin
			if (!rows_full && in_row)
				end_row();
			if (mode_reg == cce_pkg::MODE_HEADER && row_cnt == 0)
				emit(1, 16'd0, 8'd0, 1'b0, 1'b0, 1'b1, 0);
			if (mode_reg == cce_pkg::MODE_COUNT)
				emit(0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b1, row_cnt);
			parse_ph  = cce_pkg::PH_START;
			field_idx = '0;
			field_len = 0;
			row_cnt   = 0;
			in_row    = 1'b0;
			rows_full = 1'b0;
		end
		if (byte_recs.size() != 0)
			byte_recs[byte_recs.size() - 1].run_last = 1'b1;
		foreach (byte_recs[i])
			pending_recs.push_back(byte_recs[i]);
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(negedge clk) begin
		cce_pkg::rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_cnt++;
			if (pending_recs.size() == 0) begin
				$error("result with none expected: row %0d column %0d", row_number,
					col_index);
				errors++;
			end else begin
				want = pending_recs.pop_front();
				check_field("row_number", 16'(want.row_number), 16'(row_number));
				check_field("col_index", want.col_index, col_index);
				check_field("char_byte", 16'(want.char_byte), 16'(char_byte));
				check_field("has_char", 16'(want.has_char), 16'(has_char));
				check_field("field_end", 16'(want.field_end), 16'(field_end));
				check_field("is_report", 16'(want.is_report), 16'(is_report));
				check_field("tally", 16'(want.tally), 16'(tally));
				check_field("run_last", 16'(want.run_last), 16'(run_last));
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cnt = 0;
		else
			stuck_cnt++;
		if (stuck_cnt >= STUCK_LIMIT) begin
			$display("csv_column_extractor_test: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!idle_on) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall  <= 1'b0;
		end
	end

	task automatic send_byte(logic [7:0] b, bit last);
		bit stalled;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		end_of_data <= last;
		do begin
			@(negedge clk);
			stalled = in_stall;
			if (!stalled)
				predict_byte(b, last);
			@(posedge clk);
		end while (stalled);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_bytes[i])
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
		text_bytes.delete();
		texts_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_recs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == cce_pkg::REG_MODE)
			mode_reg = value[1:0];
		else
			target_reg = value;
	endtask

	task automatic configure(logic [1:0] m, logic [15:0] col);
		write_reg(cce_pkg::REG_MODE, {14'd0, m});
		write_reg(cce_pkg::REG_TARGET_COLUMN, col);
		cfg_write <= 1'b0;
	endtask

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == cce_pkg::CH_COMMA || b == cce_pkg::CH_TAB || b == cce_pkg::CH_QUOTE
			|| b == cce_pkg::CH_NEWLINE);
		return b;
	endfunction

	task automatic test_directed_column();
		configure(cce_pkg::MODE_COLUMN, 16'd3);
		add_str("\"q\"\"x\",b\t\"c\"d,\n\n\"n\nz,,");
		text_bytes.push_back(8'hFF);
		text_bytes.push_back(8'h00);
		add_str(",\n");
		send_text();
		settle();
	endtask

	task automatic test_header_and_count();
		configure(cce_pkg::MODE_HEADER, 16'd1);
		add_str("\"h\"\"1\",x\ty");
		send_text();
		settle();
		configure(cce_pkg::MODE_COUNT, 16'd1);
		add_str("\nab\n\nc");
		send_text();
		settle();
	endtask

	task automatic test_silent_settings();
		configure(cce_pkg::MODE_COLUMN, 16'd0);
		add_str("a,b\n");
		send_text();
		settle();
		configure(MODE_PARSE_ONLY, 16'd1);
		add_str("a,\"b\"\n");
		send_text();
		settle();
		configure(cce_pkg::MODE_HEADER, 16'd1);
		add_str("\n");
		send_text();
		settle();
		add_str("k");
		send_text();
		settle();
	endtask

	task automatic test_long_field();
		configure(cce_pkg::MODE_COLUMN, 16'd1);
		repeat (256) text_bytes.push_back(plain_byte());
		add_str(",z\n");
		send_text();
		settle();
	endtask

	task automatic test_header_width();
		configure(cce_pkg::MODE_HEADER, 16'd1);
		repeat (65) text_bytes.push_back(cce_pkg::CH_COMMA);
		add_str("\nx,y");
		send_text();
		settle();
	endtask

	function automatic void build_random_text(int budget);
		int nf;
		int kind;
		while (text_bytes.size() < budget) begin
			if ($urandom_range(0, 9) == 0)
				text_bytes.push_back(cce_pkg::CH_NEWLINE);
			nf = $urandom_range(1, 6);
			for (int f = 0; f < nf; f++) begin
				if (f != 0)
					text_bytes.push_back(($urandom_range(0, 4) == 0) ? cce_pkg::CH_TAB
						: cce_pkg::CH_COMMA);
				kind = $urandom_range(0, 9);
				if (kind < 5) begin
					repeat ($urandom_range(0, 5)) text_bytes.push_back(plain_byte());
				end else if (kind < 8) begin
					text_bytes.push_back(cce_pkg::CH_QUOTE);
					repeat ($urandom_range(0, 4)) begin
						case ($urandom_range(0, 7))
							0: begin
								text_bytes.push_back(cce_pkg::CH_QUOTE);
								text_bytes.push_back(cce_pkg::CH_QUOTE);
							end
							1: text_bytes.push_back(cce_pkg::CH_COMMA);
							2: text_bytes.push_back(cce_pkg::CH_TAB);
							default: text_bytes.push_back(plain_byte());
						endcase
					end
					if ($urandom_range(0, 9) != 0)
						text_bytes.push_back(cce_pkg::CH_QUOTE);
				end else begin
					repeat ($urandom_range(1, 3))
						text_bytes.push_back(8'($urandom_range(0, 255)));
				end
			end
			if ($urandom_range(0, 7) == 0)
				text_bytes.push_back(cce_pkg::CH_COMMA);
			text_bytes.push_back(cce_pkg::CH_NEWLINE);
		end
		if ($urandom_range(0, 1) == 0)
			void'(text_bytes.pop_back());
	endfunction

	task automatic test_random(int runs, bit with_idle);
		int pick;
		logic [1:0] m;
		logic [15:0] col;
		idle_on = with_idle;
		repeat (runs) begin
			pick = $urandom_range(0, 9);
			m = (pick < 4) ? cce_pkg::MODE_COLUMN : (pick < 7) ? cce_pkg::MODE_HEADER :
				(pick < 9) ? cce_pkg::MODE_COUNT : MODE_PARSE_ONLY;
			case ($urandom_range(0, 9))
				7:       col = 16'd0;
				8:       col = cce_pkg::FIELD_INDEX_MAX;
				9:       col = 16'($urandom_range(0, 65535));
				default: col = 16'($urandom_range(1, 4));
			endcase
			configure(m, col);
			build_random_text(TEXT_BUDGET);
			send_text();
			settle();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settle();
		test_directed_column();
		test_header_and_count();
		test_silent_settings();
		test_long_field();
		test_header_width();
		test_random(2, 1'b1);
		test_random(1, 1'b0);
		settle();
		$display("summary: %0d bytes in %0d texts, %0d results compared", bytes_sent,
			texts_sent, results_cnt);
		$display("summary: column, header, count and parse-only modes; quoting, field "
			, "length and header column limits");
		if (errors == 0 && pending_recs.size() == 0)
			$display("csv_column_extractor_test: clean");
		else
			$display("csv_column_extractor_test: errors");
		$finish;
	end

endmodule

/* files.f */
rtl/cce_pkg.sv
rtl/cce_parser.sv
rtl/cce_result_fifo.sv
rtl/csv_column_extractor.sv
tb/sv/csv_column_extractor_test.sv
